[rtl/bb3_pkg.sv]
// shared types, register indexes and reciprocal table of the 3x3 box blur
// no dependencies

package bb3_pkg;

  // input word: one rgb pixel
  typedef struct packed {
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } pix_t;

  // output word: one blurred pixel with its position
  typedef struct packed {
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    logic [15:0] out_row;
    logic [9:0]  out_col;
    logic        last_of_run;
  } res_t;

  // configuration register indexes
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  localparam int unsigned CfgDataW = 16;
  localparam logic [10:0] WidthReset  = 11'd640;
  localparam logic [15:0] HeightReset = 16'd480;

  // rounded mean is (2*sum + n) / (2*n), done as a multiply by a reciprocal
  localparam int unsigned RecipShift = 18;
  localparam int unsigned RecipW     = 18;
  localparam int unsigned NumerW     = 13;

  // ceil(2^18 / (2*n)), exact for any numerator below 2^13
  function automatic logic [RecipW-1:0] recip(input logic [3:0] n);
    logic [RecipW-1:0] m;
    case (n)
      4'd2:    m = 18'd65536;
      4'd3:    m = 18'd43691;
      4'd4:    m = 18'd32768;
      4'd5:    m = 18'd26215;
      4'd6:    m = 18'd21846;
      4'd7:    m = 18'd18725;
      4'd8:    m = 18'd16384;
      4'd9:    m = 18'd14564;
      default: m = 18'd131072;
    endcase
    return m;
  endfunction

endpackage

[rtl/bb3_line_mem.sv]
// line store memory: two rows above the current one, packed in one word
// depends on nothing; one write port and one registered read port

module bb3_line_mem #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned DataW = 48
) (
  input  logic                     clk_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [DataW-1:0]         rdata_o,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [DataW-1:0]         wdata_i
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/bb3_mean_unit.sv]
// two-stage rounded mean of the masked 3x3 window, per channel
// depends on bb3_pkg (pixel type, reciprocal table)

module bb3_mean_unit (
  input  logic           clk_i,
  input  bb3_pkg::pix_t  win_i [9],
  input  logic [8:0]     mask_i,
  output logic [7:0]     mean_o [3]
);

  logic [11:0]                       sum [3];
  logic [3:0]                        cnt;
  logic [bb3_pkg::NumerW-1:0]        numer_q [3];
  logic [bb3_pkg::RecipW-1:0]        recip_q;
  logic [bb3_pkg::NumerW+bb3_pkg::RecipW-1:0] prod [3];
  logic [7:0]                        mean_q [3];

  // masked channel sums and pixel count
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sum[ch] = '0;
    end
    for (int i = 0; i < 9; i++) begin
      if (mask_i[i]) begin
        sum[0] = sum[0] + 12'(win_i[i].in_red);
        sum[1] = sum[1] + 12'(win_i[i].in_green);
        sum[2] = sum[2] + 12'(win_i[i].in_blue);
      end
    end
    cnt = 4'($countones(mask_i));
  end

  // stage one: numerator 2*sum + n and reciprocal of 2*n
  always_ff @(posedge clk_i) begin
    for (int ch = 0; ch < 3; ch++) begin
      numer_q[ch] <= {sum[ch], 1'b0} + bb3_pkg::NumerW'(cnt);
    end
    recip_q <= bb3_pkg::recip(cnt);
  end

  // stage two: multiply and keep the quotient bits
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      prod[ch] = (bb3_pkg::NumerW+bb3_pkg::RecipW)'(numer_q[ch]) *
                 (bb3_pkg::NumerW+bb3_pkg::RecipW)'(recip_q);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int ch = 0; ch < 3; ch++) begin
      mean_q[ch] <= prod[ch][bb3_pkg::RecipShift +: 8];
    end
  end

  assign mean_o = mean_q;

endmodule

[rtl/box_blur_3x3_edge_cropped.sv]
// top level of the streaming 3x3 edge-cropped box blur
// depends on bb3_pkg, bb3_line_mem, bb3_mean_unit
//
//  channel | handshake                   | payload
//  --------+-----------------------------+----------------------------
//  input   | in_valid_i / in_stall_o     | in_data_i  (bb3_pkg::pix_t)
//  output  | out_valid_o / out_stall_i   | out_data_o (bb3_pkg::res_t)
//  config  | cfg_we_i                    | cfg_idx_i, cfg_wdata_i
//
// a word is accepted, then the line store does its read-modify-write, then each
// result it causes passes select, sum, multiply and output load in turn
// the line store read port and the shared mean unit set this sequence; input stalls meanwhile
// reset clears counters, window and control; the line store is not cleared
// a stalled output holds its word; the next result waits in the mean unit

module box_blur_3x3_edge_cropped #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  bb3_pkg::pix_t                    in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output bb3_pkg::res_t                    out_data_o,
  input  logic                             cfg_we_i,
  input  logic                             cfg_idx_i,
  input  logic [bb3_pkg::CfgDataW-1:0]     cfg_wdata_i
);

  localparam int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned EW = (CW + 1 > 11) ? CW + 1 : 11;
  localparam int unsigned MemDepth = 2 ** CW;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_READ = 6'b000010,
    S_SEL  = 6'b000100,
    S_SUM  = 6'b001000,
    S_MUL  = 6'b010000,
    S_OUT  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [10:0]   frame_width_q;
  logic [15:0]   frame_height_q;
  logic [CW-1:0] col_q;
  logic [15:0]   row_q;

  // per-word registers
  bb3_pkg::pix_t px_q;
  logic [CW-1:0] c_q;
  logic [15:0]   r_q;
  logic          r_ge1_q, r_ge2_q, c_ge1_q, c_ge2_q;
  logic [3:0]    pend_q;

  // per-result registers
  logic [8:0]    mask_q;
  logic [15:0]   ro_q;
  logic [CW-1:0] co_q;
  logic          last_q;

  bb3_pkg::pix_t win_q [9];
  bb3_pkg::res_t out_q;
  logic          out_valid_q;

  // clamped frame size and position of the incoming word
  logic [EW-1:0] fw_ext, w_eff, c_ext, c_eff, c_next;
  logic [15:0]   h_eff, r_eff;
  logic [16:0]   r_next;
  logic          c_last, r_last;
  logic          accept;

  always_comb begin
    fw_ext = EW'(frame_width_q);
    if (fw_ext == '0) begin
      w_eff = EW'(1);
    end else if (fw_ext > EW'(MAX_WIDTH)) begin
      w_eff = EW'(MAX_WIDTH);
    end else begin
      w_eff = fw_ext;
    end
    h_eff  = (frame_height_q == '0) ? 16'd1 : frame_height_q;
    c_ext  = EW'(col_q);
    c_eff  = (c_ext >= w_eff) ? w_eff - EW'(1) : c_ext;
    r_eff  = (row_q >= h_eff) ? h_eff - 16'd1 : row_q;
    c_last = (c_eff == w_eff - EW'(1));
    r_last = (r_eff == h_eff - 16'd1);
    c_next = c_eff + EW'(1);
    r_next = 17'(r_eff) + 17'd1;
  end

  assign accept = in_valid_i && (state_q == S_IDLE);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= bb3_pkg::WidthReset;
      frame_height_q <= bb3_pkg::HeightReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bb3_pkg::REG_FRAME_WIDTH:  frame_width_q  <= 11'(cfg_wdata_i);
        bb3_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // raster counters, wrap at frame end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      if (c_next >= w_eff) begin
        col_q <= '0;
        row_q <= (r_next >= 17'(h_eff)) ? 16'd0 : r_next[15:0];
      end else begin
        col_q <= c_next[CW-1:0];
        row_q <= r_eff;
      end
    end
  end

  // line store: word is {two rows above, row above}
  logic [47:0] mem_rdata;
  logic [23:0] top_px, mid_px;

  assign top_px = mem_rdata[47:24];
  assign mid_px = mem_rdata[23:0];

  bb3_line_mem #(
    .Depth (MemDepth),
    .DataW (48)
  ) u_line_mem (
    .clk_i   (clk_i),
    .re_i    (accept),
    .raddr_i (c_eff[CW-1:0]),
    .rdata_o (mem_rdata),
    .we_i    (state_q == S_READ),
    .waddr_i (c_q),
    .wdata_i ({mid_px, px_q})
  );

  // capture the word and the results it causes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (accept) begin
      pend_q <= {r_last && c_last, r_last && (c_eff != '0),
                 (r_eff != '0) && c_last, (r_eff != '0) && (c_eff != '0)};
    end else if (state_q == S_SEL) begin
      pend_q <= pend_q & (pend_q - 4'd1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      px_q    <= in_data_i;
      c_q     <= c_eff[CW-1:0];
      r_q     <= r_eff;
      r_ge1_q <= (r_eff >= 16'd1);
      r_ge2_q <= (r_eff >= 16'd2);
      c_ge1_q <= (c_eff >= EW'(1));
      c_ge2_q <= (c_eff >= EW'(2));
    end
  end

  // 3x3 window, shifted in when the line store data returns
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= '0;
      end
    end else if (state_q == S_READ) begin
      for (int i = 0; i < 3; i++) begin
        win_q[i*3]   <= win_q[i*3+1];
        win_q[i*3+1] <= win_q[i*3+2];
      end
      win_q[2] <= top_px;
      win_q[5] <= mid_px;
      win_q[8] <= px_q;
    end
  end

  // pick the next result: lowest pending bit, raster order
  logic [3:0] low_bit;
  logic       sel_dr, sel_dc;
  logic [2:0] row_ok, col_ok;

  always_comb begin
    low_bit = pend_q & (~pend_q + 4'd1);
    sel_dr  = low_bit[0] | low_bit[1];
    sel_dc  = low_bit[0] | low_bit[2];
    row_ok  = {1'b1, r_ge1_q, sel_dr && r_ge2_q};
    col_ok  = {1'b1, c_ge1_q, sel_dc && c_ge2_q};
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_SEL) begin
      for (int wr = 0; wr < 3; wr++) begin
        for (int wc = 0; wc < 3; wc++) begin
          mask_q[wr*3+wc] <= row_ok[wr] && col_ok[wc];
        end
      end
      ro_q   <= r_q - 16'(sel_dr);
      co_q   <= c_q - CW'(sel_dc);
      last_q <= ((pend_q & ~low_bit) == '0);
    end
  end

  logic [7:0] mean [3];

  bb3_mean_unit u_mean (
    .clk_i  (clk_i),
    .win_i  (win_q),
    .mask_i (mask_q),
    .mean_o (mean)
  );

  // output register
  logic out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_OUT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT && out_free) begin
      out_q.out_red     <= mean[0];
      out_q.out_green   <= mean[1];
      out_q.out_blue    <= mean[2];
      out_q.out_row     <= ro_q;
      out_q.out_col     <= 10'(co_q);
      out_q.last_of_run <= last_q;
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (accept) state_d = S_READ;
      S_READ: state_d = (pend_q != '0) ? S_SEL : S_IDLE;
      S_SEL:  state_d = S_SUM;
      S_SUM:  state_d = S_MUL;
      S_MUL:  state_d = S_OUT;
      S_OUT: begin
        if (out_free) begin
          state_d = (pend_q != '0) ? S_SEL : S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
